// ----- rtl/buse_pkg.sv -----
// ----------------------------------------------------------------------------
// buse_pkg: shared types for the bounded unique set engine
// transfer payloads, result codes, controller state and command/status groups
// ----------------------------------------------------------------------------
package buse_pkg;

  localparam int unsigned CAP_W     = 7;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // register word index within the configuration space
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ABSENT  = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_MOVE,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    start;     // latch request, rewind scan index
    logic    scan_rd;   // read entry at scan index, advance
    logic    last_rd;   // read the last held entry
    logic    wr_new;    // append request value, count up
    logic    wr_move;   // move last entry into matched slot, count down
    logic    load_out;  // load result register
    status_t out_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  full;
    logic  scan_end;
    logic  match;
  } dp_stat_t;

endpackage

// ----- rtl/buse_datapath.sv -----
// ----------------------------------------------------------------------------
// buse_datapath: entry memory, scan index, count and result register
// single-port-per-direction memory with registered read data
// ----------------------------------------------------------------------------
module buse_datapath import buse_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic [CAP_W-1:0] capacity,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output out_item_t        out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned UW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (UW > CAP_W) ? UW : CAP_W;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;
  logic [VALUE_W-1:0] value_r;
  kind_t              kind_r;
  logic [UW-1:0]      idx_r, idx_nxt;
  logic [UW-1:0]      used_r, used_nxt;
  logic               pend_r, pend_nxt;
  out_item_t          out_r;

  logic [UW-1:0] idx_dec, used_dec;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               wr_en, rd_en;

  assign idx_dec  = idx_r - UW'(1);
  assign used_dec = used_r - UW'(1);

  assign rd_en   = cmd.scan_rd | cmd.last_rd;
  assign rd_addr = cmd.last_rd ? used_dec[AW-1:0] : idx_r[AW-1:0];
  assign wr_en   = cmd.wr_new | cmd.wr_move;
  assign wr_addr = cmd.wr_move ? idx_dec[AW-1:0] : used_r[AW-1:0];
  assign wr_data = cmd.wr_move ? rd_data_r : value_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    pend_nxt = pend_r;
    used_nxt = used_r;
    if (cmd.start) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (cmd.scan_rd) begin
      idx_nxt  = idx_r + UW'(1);
      pend_nxt = 1'b1;
    end
    if (cmd.wr_new) begin
      used_nxt = used_r + UW'(1);
    end else if (cmd.wr_move) begin
      used_nxt = used_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      value_r <= in_data.value;
      kind_r  <= in_data.kind;
    end
    if (cmd.load_out) begin
      out_r.status <= cmd.out_status;
      out_r.count  <= COUNT_W'(used_r);
    end
  end

  // full when count reaches capacity, saturated at the memory depth
  assign stat.kind     = kind_r;
  assign stat.empty    = (used_r == '0);
  assign stat.full     = (CW'(used_r) >= CW'(capacity)) || (used_r == UW'(DEPTH));
  assign stat.scan_end = (idx_r == used_r);
  assign stat.match    = pend_r && (rd_data_r == value_r);

  assign out_data = out_r;

endmodule

// ----- rtl/buse_ctrl.sv -----
// ----------------------------------------------------------------------------
// buse_ctrl: request sequencer
// walks scan, remove move-back and result hand-off for one request at a time
// ----------------------------------------------------------------------------
module buse_ctrl import buse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state and result code
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.kind == KIND_REMOVE && stat.empty) begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_DONE;
        end else if (stat.match) begin
          if (stat.kind == KIND_INSERT) begin
            status_nxt = ST_PRESENT;
            state_nxt  = S_DONE;
          end else begin
            state_nxt  = S_LAST;
          end
        end else if (stat.scan_end) begin
          if (stat.kind == KIND_REMOVE) begin
            status_nxt = ST_ABSENT;
          end else if (stat.full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_ADDED;
          end
          state_nxt = S_DONE;
        end
      end
      S_LAST: begin
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        status_nxt = ST_REMOVED;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.out_status = status_r;
    in_ready       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        if (stat.kind == KIND_REMOVE && stat.empty) begin
          cmd.scan_rd = 1'b0;
        end else if (stat.match) begin
          cmd.scan_rd = 1'b0;
        end else if (stat.scan_end) begin
          cmd.wr_new = (stat.kind == KIND_INSERT) && !stat.full;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_LAST: begin
        cmd.last_rd = 1'b1;
      end
      S_MOVE: begin
        cmd.wr_move = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_ADDED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/bounded_unique_set_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_unique_set_engine: bounded set of distinct signed 32-bit values
// insert appends unless duplicate or full; remove swaps the last entry in
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------
//   in_      | input     | in_valid / in_ready   | in_item_t  {kind, value}
//   out_     | output    | out_valid / out_ready | out_item_t {status, count}
//   apb      | input     | psel/penable/pready   | capacity at byte addr 0
//
// steps: a request passes from accept through the scan, whose compare trails
//   the registered read, to the result step; a remove that hits adds the
//   move-back, reading the last entry and moving it into the matched slot
// reset: rst_n synchronous, empties the set and sets capacity to 64
// stalls: the result waits in an output register; the next transfer on in_
//   is taken while it waits, and the engine holds in its last step only if a
//   second result is ready before the first one is taken
//
module bounded_unique_set_engine import buse_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [CAP_W-1:0] capacity_r;
  logic             reg_hit;

  // word decode: only the capacity register exists
  assign reg_hit = (paddr[CFG_AW-1:2] == 1'(REG_CAPACITY));
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // read back zero outside the register
  assign prdata = reg_hit ? CFG_DW'(capacity_r) : '0;

  // sequencer: owns handshakes and result codes
  buse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // entry store, scan index, count and result register
  buse_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .capacity (capacity_r),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ----- rtl/buse_chk.sv -----
// ----------------------------------------------------------------------------
// buse_chk: port-level checks for the bounded unique set engine
// bound to the top level
// ----------------------------------------------------------------------------
module buse_chk import buse_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // an empty report leaves an empty set
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> (out_data.count == '0))
    else $error("empty report with nonzero count");

  // an add leaves at least one entry; checked only while DEPTH is below 128
  a_added_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_ADDED) && (DEPTH < 128) |-> (out_data.count != '0))
    else $error("add report with zero count");

endmodule

bind bounded_unique_set_engine buse_chk #(
  .DEPTH (DEPTH)
) u_buse_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

// ----- test/tb_bounded_unique_set_engine.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_unique_set_engine: self-checking bench for the unique set engine
// a short table of insert/remove requests and capacity writes, then random
// fill/drain phases, scored against a behavioral set kept in the bench or,
// for table rows with a typed-in result, against that result
module tb_bounded_unique_set_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import buse_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [CFG_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  // directed plan: a row is either a request or a capacity write
  typedef enum {ROW_REQ, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    kind_t       op;
    logic [31:0] value;
    bit          fixed;   // expected result typed in below
    status_t     st;
    logic [6:0]  cnt;
    logic [6:0]  cap;
  } plan_row_t;

  plan_row_t plan [28] = '{
    // remove from an empty set
    '{ROW_REQ, KIND_REMOVE, 32'd5,         1'b1, ST_EMPTY,   7'd0, 7'd0},
    // fill with the field extremes
    '{ROW_REQ, KIND_INSERT, 32'h0000_0000, 1'b1, ST_ADDED,   7'd1, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'h7fff_ffff, 1'b1, ST_ADDED,   7'd2, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'h8000_0000, 1'b1, ST_ADDED,   7'd3, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'hffff_ffff, 1'b1, ST_ADDED,   7'd4, 7'd0},
    // duplicate and absent value
    '{ROW_REQ, KIND_INSERT, 32'h0000_0000, 1'b1, ST_PRESENT, 7'd4, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'h0001_2345, 1'b1, ST_ABSENT,  7'd4, 7'd0},
    // remove first slot, then the entry swapped into it
    '{ROW_REQ, KIND_REMOVE, 32'h0000_0000, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'hffff_ffff, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'h5555_5555, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'haaaa_aaaa, 1'b0, ST_ADDED,   7'd0, 7'd0},
    // capacity lowered below the count
    '{ROW_CAP, KIND_INSERT, 32'd0,         1'b0, ST_ADDED,   7'd0, 7'd2},
    '{ROW_REQ, KIND_INSERT, 32'h0000_0001, 1'b1, ST_FULL,    7'd4, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'h5555_5555, 1'b1, ST_PRESENT, 7'd4, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'h8000_0000, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'h7fff_ffff, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'haaaa_aaaa, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'h0000_0001, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'h0000_0002, 1'b0, ST_ADDED,   7'd0, 7'd0},
    // zero capacity: no room for anything new
    '{ROW_CAP, KIND_INSERT, 32'd0,         1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'h0000_0003, 1'b1, ST_FULL,    7'd2, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'h0000_0001, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'h5555_5555, 1'b0, ST_ADDED,   7'd0, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'h0000_0001, 1'b1, ST_EMPTY,   7'd0, 7'd0},
    '{ROW_REQ, KIND_INSERT, 32'h0000_0009, 1'b1, ST_FULL,    7'd0, 7'd0},
    // capacity above depth saturates
    '{ROW_CAP, KIND_INSERT, 32'd0,         1'b0, ST_ADDED,   7'd0, 7'd127},
    '{ROW_REQ, KIND_INSERT, 32'h0000_0009, 1'b1, ST_ADDED,   7'd1, 7'd0},
    '{ROW_REQ, KIND_REMOVE, 32'h0000_0009, 1'b1, ST_REMOVED, 7'd0, 7'd0}
  };

  // random phases: capacity setting and number of requests
  int unsigned phase_cap [7] = '{64, 127, 1, 5, 0, 33, 64};
  int unsigned phase_len [7] = '{200, 160, 50, 60, 30, 120, 100};

  // dut signals; the ones the bench drives are known from time zero
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // bench copy of the set: held values, their count, capacity setting
  logic [31:0] held_vals [DEPTH];
  int          held_count  = 0;
  int unsigned cap_setting = CAP_RESET;

  out_item_t expected_results [$];
  int        errors     = 0;
  int        gap_pct    = 0;   // chance of a sender gap before a request
  int        stall_pct  = 0;   // chance of a receiver stall burst
  int        stall_left = 0;

  always #5 clk = ~clk;

  bounded_unique_set_engine #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  task automatic flag_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  // apply one request to the bench set and return the result it should give
  function automatic out_item_t set_apply(in_item_t req);
    out_item_t   res;
    int unsigned room;
    int          slot;
    int          i;
    room = (cap_setting > DEPTH) ? DEPTH : cap_setting;
    slot = -1;
    for (i = 0; i < held_count; i++) begin
      if (slot < 0 && held_vals[i] == req.value) begin
        slot = i;
      end
    end
    if (req.kind == KIND_INSERT) begin
      if (slot >= 0) begin
        res.status = ST_PRESENT;
      end else if (held_count >= room) begin
        res.status = ST_FULL;
      end else begin
        held_vals[held_count] = req.value;
        held_count++;
        res.status = ST_ADDED;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else if (slot >= 0) begin
      // last entry fills the hole
      held_vals[slot] = held_vals[held_count-1];
      held_count--;
      res.status = ST_REMOVED;
    end else begin
      res.status = ST_ABSENT;
    end
    res.count = COUNT_W'(held_count);
    return res;
  endfunction

  // present one request, hold it until the transfer, then queue its result;
  // valid is only lowered here when a gap is taken, so it never toggles
  // twice in one step
  task automatic send_request(in_item_t req, bit fixed, out_item_t want);
    out_item_t predicted;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = set_apply(req);
    expected_results.push_back(fixed ? want : predicted);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // setup then access phase; psel is left high so accesses can chain
  task automatic apb_access(bit wr, logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  // write capacity, read it back, mirror it in the bench
  task automatic program_capacity(int unsigned cap);
    logic [CFG_DW-1:0] rd;
    apb_access(1'b1, CFG_DW'(cap), rd);
    apb_access(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    cap_setting = cap & 32'h7f;
    if (rd[CAP_W-1:0] !== CAP_W'(cap)) begin
      flag_mismatch($sformatf("capacity read %0d after write of %0d",
                              rd[CAP_W-1:0], cap));
    end
  endtask

  // result scoreboard and receiver stalls
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result transfer with nothing outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) begin
          flag_mismatch($sformatf("status %0d, want %0d",
                                  out_data.status, want.status));
        end
        if (out_data.count !== want.count) begin
          flag_mismatch($sformatf("count %0d, want %0d",
                                  out_data.count, want.count));
        end
      end
    end
    // receiver stall bursts, the rest of a burst counted down in stall_left
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    in_item_t          req;
    out_item_t         want;
    logic [CFG_DW-1:0] rd;
    logic [31:0]       pool [DEPTH+8];
    int                pool_n;
    int                p;
    int                n;
    int                pick;
    bit                filling;
    bit                do_insert;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // capacity comes out of reset at its default
    apb_access(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[CAP_W-1:0] !== CAP_RESET) begin
      flag_mismatch($sformatf("capacity %0d after reset", rd[CAP_W-1:0]));
    end

    // directed table with moderate idling on both sides
    gap_pct   = 30;
    stall_pct = 30;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CAP) begin
        drain_results();
        program_capacity(plan[r].cap);
      end else begin
        req.kind    = plan[r].op;
        req.value   = plan[r].value;
        want.status = plan[r].st;
        want.count  = plan[r].cnt;
        send_request(req, plan[r].fixed, want);
      end
    end

    // random phases: fill hard, then drain hard, values mostly from a pool
    // a little larger than the capacity, capped at the depth, so duplicates and hits are common
    for (p = 0; p < 7; p++) begin
      drain_results();
      program_capacity(phase_cap[p]);
      if (p == 6) begin
        // closing stretch with no idling at all
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(2) == 0) ? 0 : 10 + $urandom_range(40);
        stall_pct = ($urandom_range(2) == 0) ? 0 : 10 + $urandom_range(40);
      end
      pool_n = ((phase_cap[p] > DEPTH) ? DEPTH : phase_cap[p]) + 8;
      for (n = 0; n < pool_n; n++) begin
        pool[n] = $urandom;
      end
      // keep the sign extremes and neighbors of zero in play
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;
      pool[2] = 32'h0000_0000;
      pool[3] = 32'hffff_ffff;
      for (n = 0; n < phase_len[p]; n++) begin
        filling   = (n < (phase_len[p] * 3) / 5);
        do_insert = filling ? ($urandom_range(99) < 85) : ($urandom_range(99) < 25);
        req.kind  = do_insert ? KIND_INSERT : KIND_REMOVE;
        pick      = $urandom_range(99);
        if (pick < 10) begin
          req.value = $urandom;
        end else if (pick < 25 && held_count > 0) begin
          req.value = held_vals[$urandom_range(held_count-1)];
        end else begin
          req.value = pool[$urandom_range(pool_n-1)];
        end
        send_request(req, 1'b0, '0);
      end
    end

    // wait out the last results, then a scan's worth of quiet cycles
    drain_results();
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
